/* hdl/lfu_pkg.sv */
`default_nettype none
package lfu_pkg;

   localparam int TABLE_SLOTS_DEF    = 8;
   localparam int USE_COUNT_BITS_DEF = 16;

   localparam int KIND_W    = 2;
   localparam int ID_W      = 64;
   localparam int STATUS_W  = 2;
   localparam int TIME_W    = 32;
   localparam int RDIDX_W   = 3;
   localparam int SLOTIDX_W = 3;
   localparam int OUTCOME_W = 2;
   localparam int USES_W    = 16;

   localparam logic [TIME_W-1:0] WINDOW_LENGTH_RST = 32'd86400000;

   localparam logic [KIND_W-1:0] KIND_USE      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PRESENCE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LIST     = 2'd2;
   localparam logic [KIND_W-1:0] KIND_READ     = 2'd3;

   localparam logic [OUTCOME_W-1:0] OUT_IGNORED  = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUT_FOUND    = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUT_FREE     = 2'd2;
   localparam logic [OUTCOME_W-1:0] OUT_REPLACED = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OFF = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ON  = 2'd2;

   // scan unit control
   typedef struct packed {
      logic step;
      logic first;
   } scan_ctl_type;

endpackage
`default_nettype wire

/* hdl/lfu_if.sv */
`default_nettype none
interface lfu_req_if;
   import lfu_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [ID_W-1:0]     user_id;
   logic [STATUS_W-1:0] status_code;
   logic [TIME_W-1:0]   now_time;
   logic [RDIDX_W-1:0]  read_index;
   modport source (output valid, kind, user_id, status_code, now_time, read_index,
                   input ready);
   modport sink   (input valid, kind, user_id, status_code, now_time, read_index,
                   output ready);
endinterface

interface lfu_rsp_if;
   import lfu_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [SLOTIDX_W-1:0] slot_index;
   logic [OUTCOME_W-1:0] outcome;
   logic                 window_restarted;
   logic                 entry_valid;
   logic [ID_W-1:0]      entry_id;
   logic [STATUS_W-1:0]  entry_status;
   logic [USES_W-1:0]    entry_uses;
   modport source (output valid, slot_index, outcome, window_restarted, entry_valid,
                   entry_id, entry_status, entry_uses, input ready);
   modport sink   (input valid, slot_index, outcome, window_restarted, entry_valid,
                   entry_id, entry_status, entry_uses, output ready);
endinterface

interface lfu_csr_if;
   import lfu_pkg::*;
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] window_length;
   modport source (output valid, window_length, input ready);
   modport sink   (input valid, window_length, output ready);
endinterface
`default_nettype wire

/* hdl/lfu_ram.sv */
`default_nettype none
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

/* hdl/lfu_scan.sv */
`default_nettype none
module lfu_scan #(
   parameter int TABLE_SLOTS    = lfu_pkg::TABLE_SLOTS_DEF,
   parameter int USE_COUNT_BITS = lfu_pkg::USE_COUNT_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire lfu_pkg::scan_ctl_type          ctl,
   input  wire logic [$clog2(TABLE_SLOTS)-1:0] idx,
   input  wire logic                           slot_valid,
   input  wire logic [lfu_pkg::ID_W-1:0]       slot_id,
   input  wire logic [USE_COUNT_BITS-1:0]      slot_count,
   input  wire logic [lfu_pkg::ID_W-1:0]       req_id,
   output      logic                           match_hit,
   output      logic [$clog2(TABLE_SLOTS)-1:0] match_idx,
   output      logic                           free_hit,
   output      logic [$clog2(TABLE_SLOTS)-1:0] free_idx,
   output      logic [$clog2(TABLE_SLOTS)-1:0] min_idx
);
   import lfu_pkg::*;

   localparam int IW = $clog2(TABLE_SLOTS);

   logic                      match_hit_ff, match_hit_in;
   logic                      free_hit_ff, free_hit_in;
   logic [IW-1:0]             match_idx_ff, match_idx_in;
   logic [IW-1:0]             free_idx_ff, free_idx_in;
   logic [IW-1:0]             min_idx_ff, min_idx_in;
   logic [USE_COUNT_BITS-1:0] min_cnt_ff, min_cnt_in;
   logic                      is_match, is_free;

   assign is_match = slot_valid && (slot_id == req_id);
   assign is_free  = !slot_valid;

   always_comb begin
      match_hit_in = match_hit_ff;
      match_idx_in = match_idx_ff;
      free_hit_in  = free_hit_ff;
      free_idx_in  = free_idx_ff;
      min_idx_in   = min_idx_ff;
      min_cnt_in   = min_cnt_ff;
      if (ctl.step) begin
         if (ctl.first) begin
            match_hit_in = is_match;
            match_idx_in = idx;
            free_hit_in  = is_free;
            free_idx_in  = idx;
            min_idx_in   = idx;
            min_cnt_in   = slot_count;
         end else begin
            if (!match_hit_ff && is_match) begin
               match_hit_in = 1'b1;
               match_idx_in = idx;
            end
            if (!free_hit_ff && is_free) begin
               free_hit_in = 1'b1;
               free_idx_in = idx;
            end
            // strict compare keeps the lowest index on ties
            if (slot_count < min_cnt_ff) begin
               min_idx_in = idx;
               min_cnt_in = slot_count;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_hit_ff <= 1'b0;
         free_hit_ff  <= 1'b0;
      end else begin
         match_hit_ff <= match_hit_in;
         free_hit_ff  <= free_hit_in;
      end
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      min_idx_ff   <= min_idx_in;
      min_cnt_ff   <= min_cnt_in;
   end

   assign match_hit = match_hit_ff;
   assign match_idx = match_idx_ff;
   assign free_hit  = free_hit_ff;
   assign free_idx  = free_idx_ff;
   assign min_idx   = min_idx_ff;
endmodule
`default_nettype wire

/* hdl/tracked_user_table_lfu_core.sv */
// Flow: use and presence items, and list items whose id is held, go through the
//   window check, a serial scan of every slot, decide and update before their result;
//   a list item for an unknown id ends at decide, a read skips the scan and decide,
//   and a zero id gives its result straight from the window check.
// One item at a time: a new item is taken only once the last result has been accepted.
// Reset (synchronous): all slots invalid, window not started, window length 86400000.
`default_nettype none
module tracked_user_table_lfu_core #(
   parameter int TABLE_SLOTS    = lfu_pkg::TABLE_SLOTS_DEF,
   parameter int USE_COUNT_BITS = lfu_pkg::USE_COUNT_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   lfu_req_if.sink   req_ch,
   lfu_rsp_if.source rsp_ch,
   lfu_csr_if.sink   csr_ch
);
   import lfu_pkg::*;

   localparam int IW      = $clog2(TABLE_SLOTS);
   localparam int UB      = USE_COUNT_BITS;
   localparam int ENTRY_W = ID_W + STATUS_W + UB;

   // Sequencer: WIN does the window check and starts the first RAM read,
   // SCAN walks every slot, DECIDE picks the slot and reads it,
   // UPDATE modifies and writes it back (a read writes nothing), RESP holds the result item.
   typedef enum logic [2:0] {
      S_IDLE, S_WIN, S_SCAN, S_DECIDE, S_UPDATE, S_RESP
   } state_type;

   state_type state_ff, state_in;

   // accepted item
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [STATUS_W-1:0] st_ff, st_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [RDIDX_W-1:0]  rd_ff, rd_in;

   // window
   logic [TIME_W-1:0] win_start_ff, win_start_in;
   logic [TIME_W-1:0] win_len_ff, win_len_in;
   logic [TIME_W-1:0] win_age;

   // per-slot flags in flops: slot held, and count belongs to current window
   logic [TABLE_SLOTS-1:0] valid_ff, valid_in;
   logic [TABLE_SLOTS-1:0] live_ff, live_in;

   logic [IW-1:0]        chk_ff, chk_in;
   logic [IW-1:0]        pick_ff, pick_in;
   logic [OUTCOME_W-1:0] how_ff, how_in;
   logic                 restart_ff, restart_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SLOTIDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [OUTCOME_W-1:0] rsp_outcome_ff, rsp_outcome_in;
   logic                 rsp_restart_ff, rsp_restart_in;
   logic                 rsp_evalid_ff, rsp_evalid_in;
   logic [ID_W-1:0]      rsp_eid_ff, rsp_eid_in;
   logic [STATUS_W-1:0]  rsp_est_ff, rsp_est_in;
   logic [USES_W-1:0]    rsp_euses_ff, rsp_euses_in;

   // RAM
   logic               ram_wr_en, ram_rd_en;
   logic [IW-1:0]      ram_wr_addr, ram_rd_addr;
   logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;
   logic [ID_W-1:0]     rd_id;
   logic [STATUS_W-1:0] rd_st;
   logic [UB-1:0]       rd_cnt;

   // scan
   scan_ctl_type scan_ctl;
   logic [UB-1:0] scan_cnt;
   logic          scan_last;
   logic          m_hit, f_hit;
   logic [IW-1:0] m_idx, f_idx, n_idx;

   // update datapath
   logic                found;
   logic                base_valid;
   logic [ID_W-1:0]     base_id;
   logic [STATUS_W-1:0] base_st, new_st;
   logic [UB-1:0]       base_cnt, new_cnt;

   assign rd_id  = ram_rd_data[ENTRY_W-1 -: ID_W];
   assign rd_st  = ram_rd_data[UB +: STATUS_W];
   assign rd_cnt = ram_rd_data[UB-1:0];

   assign win_age   = now_ff - win_start_ff;
   assign scan_last = (chk_ff == IW'(TABLE_SLOTS - 1));
   // a count from an older window reads as zero
   assign scan_cnt  = live_ff[chk_ff] ? rd_cnt : '0;

   assign scan_ctl.step  = (state_ff == S_SCAN);
   assign scan_ctl.first = (chk_ff == '0);

   lfu_scan #(
      .TABLE_SLOTS    (TABLE_SLOTS),
      .USE_COUNT_BITS (USE_COUNT_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .idx        (chk_ff),
      .slot_valid (valid_ff[chk_ff]),
      .slot_id    (rd_id),
      .slot_count (scan_cnt),
      .req_id     (id_ff),
      .match_hit  (m_hit),
      .match_idx  (m_idx),
      .free_hit   (f_hit),
      .free_idx   (f_idx),
      .min_idx    (n_idx)
   );

   lfu_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // slot contents before this item's own update
   assign found      = (how_ff == OUT_FOUND);
   assign base_valid = found ? valid_ff[pick_ff] : 1'b1;
   assign base_id    = found ? rd_id : id_ff;
   assign base_st    = found ? rd_st : STATUS_OFF;
   assign base_cnt   = (found && live_ff[pick_ff]) ? rd_cnt : '0;

   always_comb begin
      case (kind_ff)
         KIND_USE:      new_st = STATUS_ON;
         KIND_PRESENCE: new_st = st_ff;
         KIND_LIST:     new_st = st_ff;
         default:       new_st = base_st;
      endcase
      // saturating count
      if (kind_ff == KIND_USE && base_cnt != '1) begin
         new_cnt = base_cnt + 1'b1;
      end else begin
         new_cnt = base_cnt;
      end
   end

   assign ram_wr_addr = pick_ff;
   assign ram_wr_data = {base_id, new_st, new_cnt};

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      id_in          = id_ff;
      st_in          = st_ff;
      now_in         = now_ff;
      rd_in          = rd_ff;
      win_start_in   = win_start_ff;
      win_len_in     = win_len_ff;
      valid_in       = valid_ff;
      live_in        = live_ff;
      chk_in         = chk_ff;
      pick_in        = pick_ff;
      how_in         = how_ff;
      restart_in     = restart_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_restart_in = rsp_restart_ff;
      rsp_evalid_in  = rsp_evalid_ff;
      rsp_eid_in     = rsp_eid_ff;
      rsp_est_in     = rsp_est_ff;
      rsp_euses_in   = rsp_euses_ff;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = '0;
      ram_wr_en      = 1'b0;

      if (csr_ch.valid) begin
         win_len_in = csr_ch.window_length;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               kind_in    = req_ch.kind;
               id_in      = req_ch.user_id;
               st_in      = req_ch.status_code;
               now_in     = req_ch.now_time;
               rd_in      = req_ch.read_index;
               restart_in = 1'b0;
               state_in   = S_WIN;
            end
         end
         S_WIN: begin
            if (kind_ff == KIND_USE) begin
               if (win_start_ff == '0) begin
                  win_start_in = now_ff;
               end else if (win_age >= win_len_ff) begin
                  win_start_in = now_ff;
                  live_in      = '0;
                  restart_in   = 1'b1;
               end
            end
            // defaults for an ignored item
            rsp_index_in   = '0;
            rsp_outcome_in = OUT_IGNORED;
            rsp_evalid_in  = 1'b0;
            rsp_eid_in     = '0;
            rsp_est_in     = '0;
            rsp_euses_in   = '0;
            if (kind_ff == KIND_READ) begin
               if (32'(rd_ff) < 32'(TABLE_SLOTS)) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = IW'(rd_ff);
                  pick_in     = IW'(rd_ff);
                  how_in      = OUT_FOUND;
                  state_in    = S_UPDATE;
               end else begin
                  rsp_restart_in = 1'b0;
                  rsp_valid_in   = 1'b1;
                  state_in       = S_RESP;
               end
            end else if (id_ff == '0) begin
               rsp_restart_in = restart_in;
               rsp_valid_in   = 1'b1;
               state_in       = S_RESP;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
               chk_in      = '0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_last) begin
               state_in = S_DECIDE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = chk_ff + 1'b1;
               chk_in      = chk_ff + 1'b1;
            end
         end
         S_DECIDE: begin
            if (m_hit) begin
               pick_in = m_idx;
               how_in  = OUT_FOUND;
            end else if (f_hit) begin
               pick_in = f_idx;
               how_in  = OUT_FREE;
            end else begin
               pick_in = n_idx;
               how_in  = OUT_REPLACED;
            end
            if (!m_hit && kind_ff == KIND_LIST) begin
               // list entry for an unknown id
               rsp_restart_in = restart_ff;
               rsp_valid_in   = 1'b1;
               state_in       = S_RESP;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = pick_in;
               state_in    = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (kind_ff != KIND_READ) begin
               ram_wr_en         = 1'b1;
               valid_in[pick_ff] = 1'b1;
               live_in[pick_ff]  = 1'b1;
            end
            rsp_index_in   = SLOTIDX_W'(pick_ff);
            rsp_outcome_in = how_ff;
            rsp_restart_in = restart_ff;
            rsp_evalid_in  = base_valid;
            // a never-held slot reads as all zero
            rsp_eid_in     = base_valid ? base_id : '0;
            rsp_est_in     = base_valid ? new_st : '0;
            rsp_euses_in   = base_valid ? USES_W'(new_cnt) : '0;
            rsp_valid_in   = 1'b1;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (rsp_ch.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         win_start_ff <= '0;
         win_len_ff   <= WINDOW_LENGTH_RST;
         valid_ff     <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_start_ff <= win_start_in;
         win_len_ff   <= win_len_in;
         valid_ff     <= valid_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff        <= kind_in;
      id_ff          <= id_in;
      st_ff          <= st_in;
      now_ff         <= now_in;
      rd_ff          <= rd_in;
      chk_ff         <= chk_in;
      pick_ff        <= pick_in;
      how_ff         <= how_in;
      restart_ff     <= restart_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_restart_ff <= rsp_restart_in;
      rsp_evalid_ff  <= rsp_evalid_in;
      rsp_eid_ff     <= rsp_eid_in;
      rsp_est_ff     <= rsp_est_in;
      rsp_euses_ff   <= rsp_euses_in;
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.slot_index       = rsp_index_ff;
   assign rsp_ch.outcome          = rsp_outcome_ff;
   assign rsp_ch.window_restarted = rsp_restart_ff;
   assign rsp_ch.entry_valid      = rsp_evalid_ff;
   assign rsp_ch.entry_id         = rsp_eid_ff;
   assign rsp_ch.entry_status     = rsp_est_ff;
   assign rsp_ch.entry_uses       = rsp_euses_ff;
endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import lfu_pkg::*;

   localparam int NSLOTS      = TABLE_SLOTS_DEF;
   // Longest result latency from the header notes: window check, the scan of every
   // slot, decide, update.
   localparam int LATENCY     = NSLOTS + 3;
   // Cycles with no handshake on any channel before the run is called hung.
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 220;

   // One slot report as it leaves the block.
   typedef struct packed {
      logic [SLOTIDX_W-1:0] slot_index;
      logic [OUTCOME_W-1:0] outcome;
      logic                 window_restarted;
      logic                 entry_valid;
      logic [ID_W-1:0]      entry_id;
      logic [STATUS_W-1:0]  entry_status;
      logic [USES_W-1:0]    entry_uses;
   } slot_report_type;

   // Per accepted item: use the typed-in report instead of the predicted one.
   typedef struct packed {
      logic            typed;
      slot_report_type report;
   } report_note_type;

   // One row of the directed table.
   typedef struct {
      logic [KIND_W-1:0]   kind;
      logic [ID_W-1:0]     user_id;
      logic [STATUS_W-1:0] status_code;
      logic [TIME_W-1:0]   now_time;
      logic [RDIDX_W-1:0]  read_index;
      int                  reps;
      logic                typed;
      slot_report_type     report;
   } dir_row_type;

   logic clock;
   logic reset;

   lfu_req_if req_ch ();
   lfu_rsp_if rsp_ch ();
   lfu_csr_if csr_ch ();

   tracked_user_table_lfu_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // ---------------------------------------------------------------------
   // Shadow copy of the user table, advanced once per accepted item.
   // ---------------------------------------------------------------------
   logic                slot_valid_sh [NSLOTS];
   logic [ID_W-1:0]     slot_id_sh    [NSLOTS];
   logic [STATUS_W-1:0] slot_status_sh[NSLOTS];
   logic [USES_W-1:0]   slot_uses_sh  [NSLOTS];
   logic [TIME_W-1:0]   win_start_sh;
   logic [TIME_W-1:0]   win_len_sh;

   slot_report_type slot_reports_due[$];   // predicted reports, oldest first
   report_note_type report_notes[$];       // one note per item driven, in order

   int  failures      = 0;
   int  items_sent    = 0;
   int  reports_seen  = 0;
   int  idle_cycles   = 0;
   int  sink_stall    = 0;
   bit  sender_idle_on = 1'b1;
   bit  sink_stall_on  = 1'b1;

   dir_row_type       plan[$];
   logic [ID_W-1:0]   id_pool[11];
   logic [TIME_W-1:0] clock_ms;

   initial begin
      for (int i = 0; i < NSLOTS; i++) begin
         slot_valid_sh[i]  = 1'b0;
         slot_id_sh[i]     = '0;
         slot_status_sh[i] = STATUS_OFF;
         slot_uses_sh[i]   = '0;
      end
      win_start_sh = '0;
      win_len_sh   = WINDOW_LENGTH_RST;
   end

   function automatic int find_slot(input logic [ID_W-1:0] id);
      for (int i = 0; i < NSLOTS; i++)
         if (slot_valid_sh[i] && slot_id_sh[i] == id)
            return i;
      return -1;
   endfunction

   // Hit, else first free slot, else lowest-index slot with the fewest uses.
   // A taken or replaced slot starts over with status off and no uses.
   function automatic int claim_slot(input logic [ID_W-1:0] id,
                                     output logic [OUTCOME_W-1:0] how);
      int pick;
      pick = find_slot(id);
      if (pick >= 0) begin
         how = OUT_FOUND;
         return pick;
      end
      for (int i = NSLOTS - 1; i >= 0; i--)
         if (!slot_valid_sh[i])
            pick = i;
      if (pick >= 0) begin
         how = OUT_FREE;
      end else begin
         how  = OUT_REPLACED;
         pick = 0;
         for (int i = 1; i < NSLOTS; i++)
            if (slot_uses_sh[i] < slot_uses_sh[pick])
               pick = i;
      end
      slot_valid_sh[pick]  = 1'b1;
      slot_id_sh[pick]     = id;
      slot_status_sh[pick] = STATUS_OFF;
      slot_uses_sh[pick]   = '0;
      return pick;
   endfunction

   // Applies one item to the shadow table and returns the report it causes.
   function automatic slot_report_type apply_table_item(
      input logic [KIND_W-1:0]   kind,
      input logic [ID_W-1:0]     id,
      input logic [STATUS_W-1:0] st,
      input logic [TIME_W-1:0]   now,
      input logic [RDIDX_W-1:0]  rd);
      slot_report_type      rep;
      logic [OUTCOME_W-1:0] how;
      logic [TIME_W-1:0]    elapsed;
      int                   hit;
      rep     = '0;
      how     = OUT_IGNORED;
      hit     = -1;
      elapsed = now - win_start_sh;
      case (kind)
         KIND_USE: begin
            // a start of zero means the window has not opened yet
            if (win_start_sh == '0) begin
               win_start_sh = now;
            end else if (elapsed >= win_len_sh) begin
               win_start_sh = now;
               for (int i = 0; i < NSLOTS; i++)
                  slot_uses_sh[i] = '0;
               rep.window_restarted = 1'b1;
            end
            if (id != '0) begin
               hit = claim_slot(id, how);
               slot_status_sh[hit] = STATUS_ON;
               if (slot_uses_sh[hit] != '1)
                  slot_uses_sh[hit] = slot_uses_sh[hit] + 1'b1;
            end
         end
         KIND_PRESENCE: begin
            if (id != '0) begin
               hit = claim_slot(id, how);
               slot_status_sh[hit] = st;
            end
         end
         KIND_LIST: begin
            if (id != '0) begin
               hit = find_slot(id);
               if (hit >= 0) begin
                  how = OUT_FOUND;
                  slot_status_sh[hit] = st;
               end
            end
         end
         default: begin
            if (int'(rd) < NSLOTS) begin
               hit = int'(rd);
               how = OUT_FOUND;
            end
         end
      endcase
      rep.outcome = how;
      if (hit >= 0) begin
         rep.slot_index   = hit[SLOTIDX_W-1:0];
         rep.entry_valid  = slot_valid_sh[hit];
         rep.entry_id     = slot_id_sh[hit];
         rep.entry_status = slot_status_sh[hit];
         rep.entry_uses   = slot_uses_sh[hit];
      end
      return rep;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   // Mostly back to back, sometimes a short gap, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [ID_W-1:0] fresh_id();
      logic [ID_W-1:0] id;
      id = {$urandom(), $urandom()};
      if (id == '0)
         id = 64'd1;
      return id;
   endfunction

   // ---------------------------------------------------------------------
   // Clock and reset
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Result side backpressure
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         sink_stall   <= 0;
      end else if (sink_stall != 0) begin
         rsp_ch.ready <= 1'b0;
         sink_stall   <= sink_stall - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (sink_stall_on)
            sink_stall <= pick_gap();
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on every accepted item, check every accepted report,
   // keep the shadow window length in step with register writes.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      slot_report_type predicted, want, got;
      report_note_type note;
      logic            moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_ch.valid && csr_ch.ready) begin
            win_len_sh = csr_ch.window_length;
            moved = 1'b1;
         end
         if (req_ch.valid && req_ch.ready) begin
            predicted = apply_table_item(req_ch.kind, req_ch.user_id,
                                         req_ch.status_code, req_ch.now_time,
                                         req_ch.read_index);
            note = report_notes.pop_front();
            // typed rows still advance the shadow table, but the report they
            // are held to is the one written in the table
            slot_reports_due.push_back(note.typed ? note.report : predicted);
            moved = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            reports_seen++;
            moved = 1'b1;
            if (slot_reports_due.size() == 0) begin
               $error("slot report with no item waiting for it");
               failures++;
            end else begin
               want = slot_reports_due.pop_front();
               got.slot_index       = rsp_ch.slot_index;
               got.outcome          = rsp_ch.outcome;
               got.window_restarted = rsp_ch.window_restarted;
               got.entry_valid      = rsp_ch.entry_valid;
               got.entry_id         = rsp_ch.entry_id;
               got.entry_status     = rsp_ch.entry_status;
               got.entry_uses       = rsp_ch.entry_uses;
               check_field("slot_index", 64'(want.slot_index), 64'(got.slot_index));
               check_field("outcome", 64'(want.outcome), 64'(got.outcome));
               check_field("window_restarted", 64'(want.window_restarted),
                           64'(got.window_restarted));
               check_field("entry_valid", 64'(want.entry_valid),
                           64'(got.entry_valid));
               check_field("entry_id", want.entry_id, got.entry_id);
               check_field("entry_status", 64'(want.entry_status),
                           64'(got.entry_status));
               check_field("entry_uses", 64'(want.entry_uses), 64'(got.entry_uses));
            end
         end
         // watchdog: the block must move something within the limit
         if (moved)
            idle_cycles = 0;
         else if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end else
            idle_cycles++;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Drives one item and returns at the edge where it is taken. Every call
   // starts in the step right after a rising edge.
   task automatic send_item(input logic [KIND_W-1:0] kind,
                            input logic [ID_W-1:0] id,
                            input logic [STATUS_W-1:0] st,
                            input logic [TIME_W-1:0] now,
                            input logic [RDIDX_W-1:0] rd,
                            input logic typed,
                            input slot_report_type report);
      int              gap;
      report_note_type note;
      gap = sender_idle_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= kind;
      req_ch.user_id     <= id;
      req_ch.status_code <= st;
      req_ch.now_time    <= now;
      req_ch.read_index  <= rd;
      note.typed  = typed;
      note.report = report;
      report_notes.push_back(note);
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   // Holds the sender until every item has reported, then lets the block
   // settle for its latency.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (reports_seen < items_sent) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_window(input logic [TIME_W-1:0] len);
      csr_ch.valid         <= 1'b1;
      csr_ch.window_length <= len;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic dir_row_type row(input logic [KIND_W-1:0] kind,
                                       input logic [ID_W-1:0] id,
                                       input logic [STATUS_W-1:0] st,
                                       input logic [TIME_W-1:0] now,
                                       input logic [RDIDX_W-1:0] rd,
                                       input int reps);
      dir_row_type r;
      r.kind        = kind;
      r.user_id     = id;
      r.status_code = st;
      r.now_time    = now;
      r.read_index  = rd;
      r.reps        = reps;
      r.typed       = 1'b0;
      r.report      = '0;
      return r;
   endfunction

   function automatic dir_row_type typed_row(input logic [KIND_W-1:0] kind,
                                             input logic [ID_W-1:0] id,
                                             input logic [STATUS_W-1:0] st,
                                             input logic [TIME_W-1:0] now,
                                             input logic [RDIDX_W-1:0] rd,
                                             input slot_report_type report);
      dir_row_type r;
      r        = row(kind, id, st, now, rd, 1);
      r.typed  = 1'b1;
      r.report = report;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [TIME_W-1:0]   phase_len[5];
      logic [KIND_W-1:0]   kind;
      logic [ID_W-1:0]     id;
      int                  r;

      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.kind          <= KIND_READ;
      req_ch.user_id       <= '0;
      req_ch.status_code   <= STATUS_OFF;
      req_ch.now_time      <= '0;
      req_ch.read_index    <= '0;
      csr_ch.valid         <= 1'b0;
      csr_ch.window_length <= WINDOW_LENGTH_RST;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table, run under the reset window length of one day.
      // Empty table reads at both ends.
      plan.push_back(typed_row(KIND_READ, '0, STATUS_OFF, '0, 3'd0,
         '{3'd0, OUT_FOUND, 1'b0, 1'b0, 64'd0, STATUS_OFF, 16'd0}));
      plan.push_back(typed_row(KIND_READ, '0, STATUS_OFF, '0, 3'd7,
         '{3'd7, OUT_FOUND, 1'b0, 1'b0, 64'd0, STATUS_OFF, 16'd0}));
      // Zero id at time zero: ignored, and the window stays closed.
      plan.push_back(typed_row(KIND_USE, '0, 2'd3, 32'd0, 3'd0,
         '{3'd0, OUT_IGNORED, 1'b0, 1'b0, 64'd0, STATUS_OFF, 16'd0}));
      // First real use opens the window at 5 and takes slot 0.
      plan.push_back(typed_row(KIND_USE, '1, STATUS_OFF, 32'd5, 3'd7,
         '{3'd0, OUT_FREE, 1'b0, 1'b1, '1, STATUS_ON, 16'd1}));
      plan.push_back(typed_row(KIND_PRESENCE, 64'd1, 2'd3, '1, 3'd0,
         '{3'd1, OUT_FREE, 1'b0, 1'b1, 64'd1, 2'd3, 16'd0}));
      // List entry for an id not held: ignored.
      plan.push_back(typed_row(KIND_LIST, 64'd2, 2'd1, 32'd0, 3'd0,
         '{3'd0, OUT_IGNORED, 1'b0, 1'b0, 64'd0, STATUS_OFF, 16'd0}));
      plan.push_back(typed_row(KIND_LIST, 64'd1, STATUS_OFF, 32'd0, 3'd0,
         '{3'd1, OUT_FOUND, 1'b0, 1'b1, 64'd1, STATUS_OFF, 16'd0}));
      plan.push_back(typed_row(KIND_PRESENCE, '0, 2'd3, 32'd0, 3'd0,
         '{3'd0, OUT_IGNORED, 1'b0, 1'b0, 64'd0, STATUS_OFF, 16'd0}));
      plan.push_back(typed_row(KIND_LIST, '0, 2'd1, 32'd0, 3'd0,
         '{3'd0, OUT_IGNORED, 1'b0, 1'b0, 64'd0, STATUS_OFF, 16'd0}));
      // One ms short of expiry, then exactly at expiry.
      plan.push_back(row(KIND_USE, 64'd1, STATUS_OFF, 32'd86400004, 3'd0, 1));
      plan.push_back(row(KIND_USE, 64'd1, STATUS_OFF, 32'd86400005, 3'd0, 1));
      // Zero id still restarts an expired window.
      plan.push_back(typed_row(KIND_USE, '0, STATUS_OFF, 32'd172800005, 3'd0,
         '{3'd0, OUT_IGNORED, 1'b1, 1'b0, 64'd0, STATUS_OFF, 16'd0}));
      // Fill the rest of the table.
      for (int i = 3; i <= 8; i++)
         plan.push_back(row(KIND_PRESENCE, ID_W'(i), STATUS_W'(i % 4), 32'd0, 3'd0, 1));
      // Full table: least-used replacement, lowest index wins ties.
      plan.push_back(row(KIND_USE, 64'h8000_0000_0000_0000, STATUS_OFF,
                         32'd172800006, 3'd0, 1));
      plan.push_back(row(KIND_PRESENCE, 64'h5555_5555_5555_5555, STATUS_ON,
                         32'd0, 3'd0, 1));
      // Repeat one id back to back to build up its use count.
      plan.push_back(row(KIND_USE, 64'hAAAA_AAAA_AAAA_AAAA, 2'd1,
                         32'd172800007, 3'd0, 20));
      for (int i = 0; i < 3; i++)
         plan.push_back(row(KIND_READ, '0, STATUS_OFF, 32'd0, RDIDX_W'(i), 1));

      foreach (plan[i]) begin
         // the repeated burst runs flat out on both sides
         sender_idle_on = (plan[i].reps == 1);
         sink_stall_on  = (plan[i].reps == 1);
         for (int k = 0; k < plan[i].reps; k++)
            send_item(plan[i].kind, plan[i].user_id, plan[i].status_code,
                      plan[i].now_time, plan[i].read_index, plan[i].typed,
                      plan[i].report);
      end

      // Random phases, each under its own window length: the shortest,
      // the longest, a short random one, the reset value, a random one.
      phase_len[0] = 32'd1;
      phase_len[1] = '1;
      phase_len[2] = $urandom_range(2, 200);
      phase_len[3] = WINDOW_LENGTH_RST;
      phase_len[4] = $urandom_range(1, 32'hFFFF_FFFF);

      for (int ph = 0; ph < 5; ph++) begin
         drain();
         write_window(phase_len[ph]);
         // phase 1 runs with no idling on either side
         sender_idle_on = (ph != 1);
         sink_stall_on  = (ph != 1);
         clock_ms = $urandom();
         foreach (id_pool[i])
            id_pool[i] = fresh_id();

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold off the sender once until the block has fully drained
            if (ph == 2 && n == PHASE_ITEMS / 2) begin
               req_ch.valid <= 1'b0;
               while (reports_seen < items_sent) @(posedge clock);
            end

            r = $urandom_range(0, 99);
            if (r < 40)
               kind = KIND_USE;
            else if (r < 65)
               kind = KIND_PRESENCE;
            else if (r < 85)
               kind = KIND_LIST;
            else
               kind = KIND_READ;

            // eleven ids compete for eight slots, so replacement stays busy
            r = $urandom_range(0, 99);
            if (r < 80)
               id = id_pool[$urandom_range(0, 10)];
            else if (r < 88)
               id = '0;
            else
               id = fresh_id();

            // time mostly creeps, sometimes jumps, and is steered onto the
            // expiry boundary and the full-wrap distance now and then
            r = $urandom_range(0, 99);
            if (r < 60)
               clock_ms = clock_ms + $urandom_range(0, 3);
            else if (r < 85)
               clock_ms = clock_ms + $urandom_range(0, 300);
            else if (r < 90)
               clock_ms = $urandom();
            else if (r < 96)
               clock_ms = win_start_sh + win_len_sh - $urandom_range(0, 1);
            else
               clock_ms = win_start_sh - 1'b1;

            send_item(kind, id, STATUS_W'($urandom_range(0, 3)), clock_ms,
                      RDIDX_W'($urandom_range(0, NSLOTS - 1)), 1'b0, '0);
         end
      end

      req_ch.valid <= 1'b0;
      while (reports_seen < items_sent) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (failures == 0 && slot_reports_due.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
